FILE: sv/sitk_pkg.sv
// Package for the skin influence top-k table: transaction types, slot layout,
// status and operation codes, and parameter defaults. No dependencies.
package sitk_pkg;

  localparam int VERTEX_W = 12;
  localparam int JOINT_W  = 8;
  localparam int WEIGHT_W = 16;
  localparam int SLOT_W   = 2;

  // Normalization: quotient of (w << 16 + sum/2) / sum is at most 65536.
  localparam int FRAC_W  = 16;
  localparam int QUOT_W  = FRAC_W + 1;
  localparam int NUMER_W = WEIGHT_W + FRAC_W + 1;

  localparam int DEF_VERTEX_COUNT   = 4096;
  localparam int DEF_MAX_INFLUENCES = 4;
  localparam int DEF_JOINT_COUNT    = 256;
  localparam int DEF_SUM_W          = WEIGHT_W + $clog2(DEF_MAX_INFLUENCES);

  typedef enum logic [0:0] {
    OP_INSERT   = 1'b0,
    OP_FINALIZE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_FILL    = 2'd0,
    ST_REPLACE = 2'd1,
    ST_DROP    = 2'd2,
    ST_NORM    = 2'd3
  } status_e;

  typedef struct packed {
    op_e                 operation;
    logic [VERTEX_W-1:0] vertex_index;
    logic [JOINT_W-1:0]  joint_index;
    logic [WEIGHT_W-1:0] weight_value;
  } in_t;

  typedef struct packed {
    status_e             status;
    logic [SLOT_W-1:0]   slot;
    logic [JOINT_W-1:0]  slot_joint;
    logic [WEIGHT_W-1:0] slot_weight;
    logic                last;
  } out_t;

  // One influence slot as held in the store.
  typedef struct packed {
    logic [JOINT_W-1:0]  joint;
    logic [WEIGHT_W-1:0] weight;
  } slot_t;

endpackage

FILE: sv/sitk_store.sv
// Per-vertex slot store: one row of slots per vertex, one read and one write port.
// Sweeps every row to zero after reset. Depends on sitk_pkg.
module sitk_store #(
  parameter int VERTEX_COUNT   = sitk_pkg::DEF_VERTEX_COUNT,
  parameter int MAX_INFLUENCES = sitk_pkg::DEF_MAX_INFLUENCES,
  parameter int ADDR_W         = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     rd_en_i,
  input  logic [ADDR_W-1:0]                        rd_addr_i,
  output sitk_pkg::slot_t [MAX_INFLUENCES-1:0]     rd_row_o,
  input  logic                                     wr_en_i,
  input  logic [ADDR_W-1:0]                        wr_addr_i,
  input  sitk_pkg::slot_t [MAX_INFLUENCES-1:0]     wr_row_i,
  output logic                                     busy_o
);

  sitk_pkg::slot_t [MAX_INFLUENCES-1:0] mem [VERTEX_COUNT];
  sitk_pkg::slot_t [MAX_INFLUENCES-1:0] rd_row_q;

  logic [ADDR_W-1:0] clr_addr_q;
  logic              clr_busy_q;

  logic                                 we;
  logic [ADDR_W-1:0]                    wa;
  sitk_pkg::slot_t [MAX_INFLUENCES-1:0] wd;

  // The clearing sweep owns the write port until every row is zero.
  always_comb begin
    if (clr_busy_q) begin
      we = 1'b1;
      wa = clr_addr_q;
      wd = '0;
    end else begin
      we = wr_en_i;
      wa = wr_addr_i;
      wd = wr_row_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == ADDR_W'(VERTEX_COUNT - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en_i) begin
      rd_row_q <= mem[rd_addr_i];
    end
  end

  assign rd_row_o = rd_row_q;
  assign busy_o   = clr_busy_q;

endmodule

FILE: sv/sitk_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, for weight normalization.
// Depends on sitk_pkg for the numerator and quotient widths.
module sitk_div #(
  parameter int SUM_W = sitk_pkg::DEF_SUM_W
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [sitk_pkg::NUMER_W-1:0] numer_i,
  input  logic [SUM_W-1:0]             denom_i,
  output logic [sitk_pkg::QUOT_W-1:0]  quot_o,
  output logic                         done_o
);

  localparam int QW    = sitk_pkg::QUOT_W;
  localparam int CNT_W = $clog2(QW);

  // The caller guarantees the numerator's upper part is below the divisor,
  // so the quotient fits in QW bits and the remainder starts from it.
  logic [SUM_W-1:0] rem_q, rem_d;
  logic [QW-1:0]    lo_q, lo_d;
  logic [SUM_W-1:0] den_q, den_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [SUM_W:0] shifted;
  logic [SUM_W:0] diff;
  logic           ge;

  always_comb begin
    shifted = {rem_q, lo_q[QW-1]};
    ge      = (shifted >= {1'b0, den_q});
    diff    = shifted - {1'b0, den_q};

    rem_d  = rem_q;
    lo_d   = lo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;

    if (start_i) begin
      rem_d  = SUM_W'(numer_i[sitk_pkg::NUMER_W-1:QW]);
      lo_d   = numer_i[QW-1:0];
      den_d  = denom_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[SUM_W-1:0] : shifted[SUM_W-1:0];
      lo_d  = {lo_q[QW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(QW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      lo_q   <= '0;
      den_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      lo_q   <= lo_d;
      den_q  <= den_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign quot_o = lo_q;
  assign done_o = done_q;

endmodule

FILE: sv/skin_influence_top_k_table.sv
// Top level of the skin influence top-k table: sequencer, slot store and divider.
// Depends on sitk_pkg, sitk_store and sitk_div.
//
//   Channel  Dir  Payload          Valid         Stall
//   in       in   sitk_pkg::in_t   in_valid_i    in_stall_o
//   out      out  sitk_pkg::out_t  out_valid_o   out_stall_i
//
// After reset the store is swept to zero, one vertex row per cycle, and in_stall_o
// stays high during the sweep.
// An insert reads the row, compares one slot per cycle in the scan, then does the
// write-back and gives the result together once the output register is free.
// A finalize accumulates the sum one slot per cycle, then each slot goes through
// the shared divider and is reported, then the row is written back. A zero-sum
// vertex skips the divider and reports each slot unchanged.
// One transaction is worked on at a time. A finished result sits in the output
// register, so the next input transaction is taken while it waits; a stalled
// output holds the sequencer only when it has a new result to deliver.
module skin_influence_top_k_table #(
  parameter int VERTEX_COUNT   = sitk_pkg::DEF_VERTEX_COUNT,
  parameter int MAX_INFLUENCES = sitk_pkg::DEF_MAX_INFLUENCES,
  parameter int JOINT_COUNT    = sitk_pkg::DEF_JOINT_COUNT
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  sitk_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output sitk_pkg::out_t out_o
);

  localparam int ADDR_W = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
  localparam int IDX_W  = (MAX_INFLUENCES > 1) ? $clog2(MAX_INFLUENCES) : 1;
  localparam int SUM_W  = sitk_pkg::WEIGHT_W + $clog2(MAX_INFLUENCES);
  localparam int W      = sitk_pkg::WEIGHT_W;
  localparam int NW     = sitk_pkg::NUMER_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_INS_OUT,
    S_DROP_OUT,
    S_SUM,
    S_DIV_START,
    S_DIV_WAIT,
    S_FIN_OUT,
    S_WB
  } state_e;

  state_e                               state_q, state_d;
  sitk_pkg::in_t                        in_q, in_d;
  sitk_pkg::slot_t [MAX_INFLUENCES-1:0] row_q, row_d;
  logic [IDX_W-1:0]                     idx_q, idx_d;
  logic [SUM_W-1:0]                     sum_q, sum_d;
  logic                                 empty_found_q, empty_found_d;
  logic [IDX_W-1:0]                     empty_idx_q, empty_idx_d;
  logic [W-1:0]                         min_w_q, min_w_d;
  logic [IDX_W-1:0]                     min_idx_q, min_idx_d;
  logic                                 out_valid_q, out_valid_d;
  sitk_pkg::out_t                       out_q, out_d;

  // Store and divider hookup.
  logic                                 store_busy;
  logic                                 rd_en;
  sitk_pkg::slot_t [MAX_INFLUENCES-1:0] rd_row;
  logic                                 wr_en;
  sitk_pkg::slot_t [MAX_INFLUENCES-1:0] wr_row;
  logic                                 div_start;
  logic [NW-1:0]                        div_numer;
  logic [sitk_pkg::QUOT_W-1:0]          div_quot;
  logic                                 div_done;

  logic                                 accept;
  logic                                 out_free;
  logic                                 vertex_ok;
  logic                                 joint_ok;
  logic                                 idx_last;
  logic [W-1:0]                         cur_w;
  logic [IDX_W-1:0]                     target;
  sitk_pkg::slot_t [MAX_INFLUENCES-1:0] ins_row;
  logic [W-1:0]                         norm_w;

  assign in_stall_o = (state_q != S_IDLE) || store_busy;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign vertex_ok = (32'(in_i.vertex_index) < VERTEX_COUNT);
  assign joint_ok  = (32'(in_i.joint_index) < JOINT_COUNT);
  assign idx_last  = (idx_q == IDX_W'(MAX_INFLUENCES - 1));
  assign cur_w     = row_q[idx_q].weight;

  // Rounded numerator for the current slot: (w << 16) + sum / 2.
  assign div_numer = (NW'(cur_w) << sitk_pkg::FRAC_W) + NW'(sum_q >> 1);

  // A quotient of exactly one saturates to the largest Q0.16 value.
  assign norm_w = div_quot[sitk_pkg::QUOT_W-1] ? '1 : div_quot[W-1:0];

  // Insert target: the lowest empty slot if any, else the lowest smallest one.
  always_comb begin
    target  = empty_found_q ? empty_idx_q : min_idx_q;
    ins_row = row_q;
    ins_row[target].weight = in_q.weight_value;
    ins_row[target].joint  = in_q.joint_index;
  end

  always_comb begin
    state_d       = state_q;
    in_d          = in_q;
    row_d         = row_q;
    idx_d         = idx_q;
    sum_d         = sum_q;
    empty_found_d = empty_found_q;
    empty_idx_d   = empty_idx_q;
    min_w_d       = min_w_q;
    min_idx_d     = min_idx_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_d         = out_q;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    wr_row        = row_q;
    div_start     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          in_d = in_i;
          if (!vertex_ok && in_i.operation == sitk_pkg::OP_FINALIZE) begin
            state_d = S_IDLE;
          end else if (!vertex_ok || !joint_ok &&
                       in_i.operation == sitk_pkg::OP_INSERT) begin
            state_d = S_DROP_OUT;
          end else begin
            rd_en   = 1'b1;
            state_d = S_LOAD;
          end
        end
      end

      S_LOAD: begin
        row_d         = rd_row;
        idx_d         = '0;
        sum_d         = '0;
        empty_found_d = 1'b0;
        state_d = (in_q.operation == sitk_pkg::OP_FINALIZE) ? S_SUM : S_SCAN;
      end

      S_SCAN: begin
        if (!empty_found_q && cur_w == '0) begin
          empty_found_d = 1'b1;
          empty_idx_d   = idx_q;
        end
        if (idx_q == '0 || cur_w < min_w_q) begin
          min_w_d   = cur_w;
          min_idx_d = idx_q;
        end
        if (idx_last) begin
          state_d = S_INS_OUT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_INS_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d.last  = 1'b1;
          out_d.slot  = sitk_pkg::SLOT_W'(target);
          if (empty_found_q || in_q.weight_value > min_w_q) begin
            wr_en             = 1'b1;
            wr_row            = ins_row;
            row_d             = ins_row;
            out_d.status      = empty_found_q ? sitk_pkg::ST_FILL : sitk_pkg::ST_REPLACE;
            out_d.slot_joint  = in_q.joint_index;
            out_d.slot_weight = in_q.weight_value;
          end else begin
            out_d.status      = sitk_pkg::ST_DROP;
            out_d.slot_joint  = row_q[min_idx_q].joint;
            out_d.slot_weight = row_q[min_idx_q].weight;
          end
          state_d = S_IDLE;
        end
      end

      S_DROP_OUT: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.status      = sitk_pkg::ST_DROP;
          out_d.slot        = '0;
          out_d.slot_joint  = '0;
          out_d.slot_weight = '0;
          out_d.last        = 1'b1;
          state_d           = S_IDLE;
        end
      end

      S_SUM: begin
        sum_d = sum_q + SUM_W'(cur_w);
        if (idx_last) begin
          idx_d   = '0;
          state_d = S_DIV_START;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_DIV_START: begin
        // A zero-sum vertex is reported unchanged.
        if (sum_q == '0) begin
          state_d = S_FIN_OUT;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV_WAIT;
        end
      end

      S_DIV_WAIT: begin
        if (div_done) begin
          row_d[idx_q].weight = norm_w;
          state_d             = S_FIN_OUT;
        end
      end

      S_FIN_OUT: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.status      = sitk_pkg::ST_NORM;
          out_d.slot        = sitk_pkg::SLOT_W'(idx_q);
          out_d.slot_joint  = row_q[idx_q].joint;
          out_d.slot_weight = row_q[idx_q].weight;
          out_d.last        = idx_last;
          if (idx_last) begin
            state_d = S_WB;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_DIV_START;
          end
        end
      end

      S_WB: begin
        wr_en   = 1'b1;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      in_q          <= '0;
      row_q         <= '0;
      idx_q         <= '0;
      sum_q         <= '0;
      empty_found_q <= 1'b0;
      empty_idx_q   <= '0;
      min_w_q       <= '0;
      min_idx_q     <= '0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      state_q       <= state_d;
      in_q          <= in_d;
      row_q         <= row_d;
      idx_q         <= idx_d;
      sum_q         <= sum_d;
      empty_found_q <= empty_found_d;
      empty_idx_q   <= empty_idx_d;
      min_w_q       <= min_w_d;
      min_idx_q     <= min_idx_d;
      out_valid_q   <= out_valid_d;
      out_q         <= out_d;
    end
  end

  sitk_store #(
    .VERTEX_COUNT  (VERTEX_COUNT),
    .MAX_INFLUENCES(MAX_INFLUENCES),
    .ADDR_W        (ADDR_W)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .rd_addr_i(ADDR_W'(in_i.vertex_index)),
    .rd_row_o (rd_row),
    .wr_en_i  (wr_en),
    .wr_addr_i(ADDR_W'(in_q.vertex_index)),
    .wr_row_i (wr_row),
    .busy_o   (store_busy)
  );

  sitk_div #(
    .SUM_W(SUM_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .numer_i(div_numer),
    .denom_i(sum_q),
    .quot_o (div_quot),
    .done_o (div_done)
  );

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

FILE: sv/sitk_checker.sv
// Port-level checker for the skin influence top-k table, bound to the top level.
// Depends on sitk_pkg and skin_influence_top_k_table.
module sitk_port_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input sitk_pkg::in_t  in_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input sitk_pkg::out_t out_o
);

  // A stalled result is held unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled output transaction changed");

  // An accepted insert keeps the block busy on the following cycle.
  a_insert_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_i.operation == sitk_pkg::OP_INSERT |=> in_stall_o)
    else $error("insert accepted without the block going busy");

  // Only finalize results come in groups; every insert result is the last one.
  a_insert_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status != sitk_pkg::ST_NORM |-> out_o.last)
    else $error("insert result without last");

  // A replacement beats a nonzero minimum, so its weight is never zero.
  a_replace_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status == sitk_pkg::ST_REPLACE |-> out_o.slot_weight != '0)
    else $error("replacement with zero weight");

endmodule

bind skin_influence_top_k_table sitk_port_checker u_sitk_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_i       (in_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_o      (out_o)
);

FILE: test/sitk_checker.sv
// Checker for the skin influence top-k table: watches both channels, keeps its own
// copy of the slot store, predicts every result and compares it field by field.
// Depends on sitk_pkg for the transaction types and the status codes.
module sitk_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  sitk_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  sitk_pkg::out_t out_data_i,
  output int             mismatch_count_o,
  output int             pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VERTICES    = sitk_pkg::DEF_VERTEX_COUNT;
  localparam int SLOTS       = sitk_pkg::DEF_MAX_INFLUENCES;
  localparam int JOINTS      = sitk_pkg::DEF_JOINT_COUNT;
  localparam int REPORT_MAX  = 10;
  localparam int WW          = sitk_pkg::WEIGHT_W;
  localparam logic [WW-1:0] WEIGHT_MAX = {WW{1'b1}};

  logic [WW-1:0]                weight_mem [VERTICES*SLOTS];
  logic [sitk_pkg::JOINT_W-1:0] joint_mem  [VERTICES*SLOTS];
  sitk_pkg::out_t               expected_slots [$];
  int                           bad_count;

  initial begin
    bad_count        = 0;
    mismatch_count_o = 0;
    pending_count_o  = 0;
    for (int i = 0; i < VERTICES * SLOTS; i++) begin
      weight_mem[i] = '0;
      joint_mem[i]  = '0;
    end
  end

  function automatic string slot_text(input sitk_pkg::out_t r);
    return $sformatf("status=%0d slot=%0d joint=%0d weight=%0d last=%0b",
                     r.status, r.slot, r.slot_joint, r.slot_weight, r.last);
  endfunction

  // Applies one accepted transaction to the shadow store and queues its results.
  task automatic predict_influence(input sitk_pkg::in_t item);
    int                             base;
    int                             target;
    logic [WW-1:0]                  min_w;
    logic [sitk_pkg::DEF_SUM_W-1:0] sum;
    logic [sitk_pkg::NUMER_W:0]     numer;
    logic [sitk_pkg::NUMER_W:0]     quot;
    sitk_pkg::out_t                 r;
    r    = '0;
    base = int'(item.vertex_index) * SLOTS;
    if (int'(item.vertex_index) >= VERTICES ||
        (item.operation == sitk_pkg::OP_INSERT && int'(item.joint_index) >= JOINTS)) begin
      // Out-of-range addresses touch nothing; only an insert reports a drop.
      if (item.operation == sitk_pkg::OP_INSERT) begin
        r.status = sitk_pkg::ST_DROP;
        r.last   = 1'b1;
        expected_slots.push_back(r);
      end
    end else if (item.operation == sitk_pkg::OP_INSERT) begin
      target = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (target < 0 && weight_mem[base+i] == '0) target = i;
      end
      r.status = sitk_pkg::ST_FILL;
      r.last   = 1'b1;
      if (target < 0) begin
        // Full vertex: the first slot holding the smallest weight is the victim.
        target = 0;
        min_w  = weight_mem[base];
        for (int i = 1; i < SLOTS; i++) begin
          if (weight_mem[base+i] < min_w) begin
            min_w  = weight_mem[base+i];
            target = i;
          end
        end
        r.status = (item.weight_value > min_w) ? sitk_pkg::ST_REPLACE : sitk_pkg::ST_DROP;
      end
      if (r.status != sitk_pkg::ST_DROP) begin
        weight_mem[base+target] = item.weight_value;
        joint_mem[base+target]  = item.joint_index;
      end
      r.slot        = sitk_pkg::SLOT_W'(target);
      r.slot_joint  = joint_mem[base+target];
      r.slot_weight = weight_mem[base+target];
      expected_slots.push_back(r);
    end else begin
      sum = '0;
      for (int i = 0; i < SLOTS; i++) sum += weight_mem[base+i];
      for (int i = 0; i < SLOTS; i++) begin
        if (sum != '0) begin
          // Round to nearest with halves up, then saturate to the weight range.
          numer = {weight_mem[base+i], {sitk_pkg::FRAC_W{1'b0}}} + (sum >> 1);
          quot  = numer / sum;
          if (quot > WEIGHT_MAX) quot = WEIGHT_MAX;
          weight_mem[base+i] = quot[WW-1:0];
        end
        r.status      = sitk_pkg::ST_NORM;
        r.slot        = sitk_pkg::SLOT_W'(i);
        r.slot_joint  = joint_mem[base+i];
        r.slot_weight = weight_mem[base+i];
        r.last        = (i == SLOTS - 1);
        expected_slots.push_back(r);
      end
    end
  endtask

  always @(posedge clk_i) begin
    sitk_pkg::out_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_slots.size() == 0) begin
          bad_count++;
          if (bad_count <= REPORT_MAX)
            $display("unexpected result: %s", slot_text(out_data_i));
        end else begin
          want = expected_slots.pop_front();
          if (out_data_i.status !== want.status || out_data_i.slot !== want.slot ||
              out_data_i.slot_joint !== want.slot_joint ||
              out_data_i.slot_weight !== want.slot_weight ||
              out_data_i.last !== want.last) begin
            bad_count++;
            if (bad_count <= REPORT_MAX)
              $display("mismatch: expected %s, actual %s",
                       slot_text(want), slot_text(out_data_i));
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict_influence(in_data_i);
      mismatch_count_o <= bad_count;
      pending_count_o  <= expected_slots.size();
    end
  end

endmodule

FILE: test/tb_top.sv
// Top of the skin influence top-k table testbench: clock, reset, stimulus, receiver
// stalls, watchdog and verdict. Depends on sitk_pkg, the block and sitk_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // The block sweeps its whole store after reset, and a finalize can be held up
  // by heavy receiver stalls, so the watchdog allows a generous stretch without
  // any transaction on either channel.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_ITEMS   = 200;
  localparam int PHASES         = 4;
  localparam int HOT_VERTICES   = 8;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_stall;
  sitk_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  sitk_pkg::out_t out_data;

  int mismatches;
  int pending;

  // Idling control. The sender's percentage is only read by the stimulus
  // process; the receiver's is handed over with nonblocking assignments.
  int   sender_idle_pct = 0;
  int   stall_pct       = 0;
  logic hold_req        = 1'b0;
  logic hold_served     = 1'b0;
  int   hold_left       = 0;
  int   items_sent      = 0;
  int   hot_vertex [HOT_VERTICES];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  skin_influence_top_k_table u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_data)
  );

  sitk_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .mismatch_count_o (mismatches),
    .pending_count_o  (pending)
  );

  // Receiver. A long hold-off, once requested, is counted here in cycles and
  // keeps the output stalled so that the block backs up into its input.
  // Otherwise the stall is drawn per cycle from the current percentage.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_served) begin
      hold_left   <= HOLD_CYCLES;
      hold_served <= 1'b1;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Offers one input transaction and returns at the edge that accepts it.
  // Valid is only lowered for idle cycles drawn before the transaction, never
  // because of the stall, and the payload holds still while stalled.
  task automatic offer_influence(input sitk_pkg::in_t item);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
  endtask

  task automatic insert_at(input int vertex, input int joint, input int weight);
    sitk_pkg::in_t item;
    item.operation    = sitk_pkg::OP_INSERT;
    item.vertex_index = sitk_pkg::VERTEX_W'(vertex);
    item.joint_index  = sitk_pkg::JOINT_W'(joint);
    item.weight_value = sitk_pkg::WEIGHT_W'(weight);
    offer_influence(item);
  endtask

  task automatic finalize_at(input int vertex);
    sitk_pkg::in_t item;
    item.operation    = sitk_pkg::OP_FINALIZE;
    item.vertex_index = sitk_pkg::VERTEX_W'(vertex);
    item.joint_index  = sitk_pkg::JOINT_W'($urandom());
    item.weight_value = sitk_pkg::WEIGHT_W'($urandom());
    offer_influence(item);
  endtask

  // Stops offering and waits until the checker expects nothing more. The first
  // edge lets the pending count catch up with the last accepted transaction.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Weights lean toward zero, small and large values so that slots fill, ties
  // occur and replacements both succeed and fail.
  function automatic logic [sitk_pkg::WEIGHT_W-1:0] random_weight();
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2, 3: return sitk_pkg::WEIGHT_W'($urandom_range(1, 255));
      4, 5:    return sitk_pkg::WEIGHT_W'($urandom_range(49152, 65535));
      default: return sitk_pkg::WEIGHT_W'($urandom());
    endcase
  endfunction

  // A well-formed sequence: a run of inserts on one vertex, mostly closed by
  // a finalize. Most vertices come from a small pool so that they fill up.
  task automatic send_vertex_burst();
    int vertex;
    int count;
    if ($urandom_range(0, 99) < 85) vertex = hot_vertex[$urandom_range(0, HOT_VERTICES - 1)];
    else vertex = $urandom_range(0, sitk_pkg::DEF_VERTEX_COUNT - 1);
    count = $urandom_range(1, 7);
    repeat (count) insert_at(vertex, $urandom_range(0, 255), random_weight());
    if ($urandom_range(0, 99) < 70) finalize_at(vertex);
  endtask

  // Noise: any operation on any vertex with fully random fields.
  task automatic send_noise_item();
    sitk_pkg::in_t item;
    item              = '0;
    item.operation    = ($urandom_range(0, 1) != 0) ? sitk_pkg::OP_FINALIZE
                                                    : sitk_pkg::OP_INSERT;
    item.vertex_index = sitk_pkg::VERTEX_W'($urandom());
    item.joint_index  = sitk_pkg::JOINT_W'($urandom());
    item.weight_value = sitk_pkg::WEIGHT_W'($urandom());
    offer_influence(item);
  endtask

  // Watchdog: ends the run when no transaction moves on either channel for
  // too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    int phase_end;
    int sender_pcts [PHASES];
    int stall_pcts  [PHASES];
    // Idling phases: none, sender idle, receiver stalling, both lightly.
    sender_pcts = '{0, 75, 0, 14};
    stall_pcts  = '{0, 0, 75, 14};
    foreach (hot_vertex[i]) hot_vertex[i] = $urandom_range(0, sitk_pkg::DEF_VERTEX_COUNT - 1);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Vertex 0 fills all four slots, including a zero-weight
    // insert that leaves its slot empty, then sees drops on equal and smaller
    // weights and a replacement of the smallest slot.
    insert_at(0, 1, 100);
    insert_at(0, 2, 300);
    insert_at(0, 3, 0);
    insert_at(0, 4, 200);
    insert_at(0, 255, 65535);
    insert_at(0, 5, 100);
    insert_at(0, 6, 50);
    insert_at(0, 7, 101);
    finalize_at(0);
    // A second finalize renormalizes values that already sum to about one.
    finalize_at(0);
    // A vertex that was never written has a zero sum and stays unchanged.
    finalize_at(5);
    // A lone full-scale weight normalizes to one and saturates.
    insert_at(4095, 0, 65535);
    finalize_at(4095);
    // Equal weights everywhere: the replacement picks the lowest slot.
    insert_at(7, 10, 1000);
    insert_at(7, 11, 1000);
    insert_at(7, 12, 1000);
    insert_at(7, 13, 1000);
    insert_at(7, 14, 1001);
    // Weights whose normalized values land exactly on a half round upward.
    insert_at(9, 20, 1);
    insert_at(9, 21, 65535);
    insert_at(9, 22, 65535);
    insert_at(9, 23, 1);
    finalize_at(9);
    wait_for_drain();

    // Random part, split over the idling phases. The first phase also holds
    // the receiver off for a long stretch while the sender keeps offering.
    for (int phase = 0; phase < PHASES; phase++) begin
      sender_idle_pct = sender_pcts[phase];
      stall_pct      <= stall_pcts[phase];
      if (phase == 0) hold_req <= 1'b1;
      phase_end = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 99) < 12) send_noise_item();
        else send_vertex_burst();
      end
      wait_for_drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
